[rtl/scp_pkg.sv]
// Package for the sequenced command line parser.
// Reply and error codes, keyword table, queue entry type. No dependencies.
package scp_pkg;

    localparam int KW_COUNT = 5;
    localparam int KW_PING = 0;
    localparam int KW_STATUS = 1;
    localparam int KW_RESET = 2;
    localparam int KW_CANCEL = 3;
    localparam int KW_HELLO = 4;
    localparam int TOK_POS_W = 7;
    localparam logic [TOK_POS_W-1:0] TOK_POS_MAX = 7'd127;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_OPEN = 2'd1,
        CMD_DETACH = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_READY = 3'd0,
        KIND_PONG = 3'd1,
        KIND_ACK_RESET = 3'd2,
        KIND_STATE = 3'd3,
        KIND_ERROR = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ERR_BAD_SEQ = 3'd0,
        ERR_FIELDS = 3'd1,
        ERR_OLD_SEQ = 3'd2,
        ERR_BAD_CMD = 3'd3,
        ERR_BAD_HELLO = 3'd4,
        ERR_BAD_PROTO = 3'd5,
        ERR_TOO_LONG = 3'd6
    } t_err;

    typedef enum logic [1:0] {
        NUM_EMPTY = 2'd0,
        NUM_PLUS = 2'd1,
        NUM_VALID = 2'd2,
        NUM_BAD = 2'd3
    } t_num;

    typedef struct packed {
        logic                ready_evt;
        logic                overflow;
        logic [1:0]          tok_cnt;
        logic [KW_COUNT-1:0] kw_alive;
        logic                num_valid;
        logic [31:0]         num_val;
        logic                mounted;
    } t_line_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [TOK_POS_W-1:0] kw_len(input int k);
        logic [TOK_POS_W-1:0] r;
        unique case (k)
            KW_PING:   r = 7'd4;
            KW_STATUS: r = 7'd6;
            KW_RESET:  r = 7'd5;
            KW_CANCEL: r = 7'd6;
            default:   r = 7'd5;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(input int k, input logic [2:0] p);
        logic [47:0] s;
        unique case (k)
            KW_PING:   s = {"PING", 16'h0};
            KW_STATUS: s = "STATUS";
            KW_RESET:  s = {"RESET", 8'h0};
            KW_CANCEL: s = "CANCEL";
            default:   s = {"HELLO", 8'h0};
        endcase
        return s[8'd47 - {p, 3'b000} -: 8];
    endfunction

endpackage

[rtl/scp_ifs.sv]
// Handshake channels for the command line parser: input word, reply, config.
// No dependencies.
interface scp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic       link_mounted;
    modport source (output valid, cmd, rx_byte, link_mounted, input ready);
    modport sink (input valid, cmd, rx_byte, link_mounted, output ready);
endinterface

interface scp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reply_kind;
    logic [2:0]  error_code;
    logic [31:0] reply_seq;
    logic        reported_mounted;
    logic [31:0] reported_prev_seq;
    logic        is_replay;
    modport source (output valid, reply_kind, error_code, reply_seq, reported_mounted,
                    reported_prev_seq, is_replay, input ready);
    modport sink (input valid, reply_kind, error_code, reply_seq, reported_mounted,
                  reported_prev_seq, is_replay, output ready);
endinterface

interface scp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/scp_front.sv]
// Front end: tokenizes words; pushes a record per open and per non-blank LF.
// Depends on scp_pkg.
module scp_front #(
    parameter int LINE_CAPACITY = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [1:0]           i_cmd,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_link_mounted,
    input  logic                 i_q_full,
    output logic                 o_ready,
    output logic                 o_push,
    output scp_pkg::t_line_rec   o_rec
);
    localparam int CW = $clog2(LINE_CAPACITY);
    localparam logic [CW:0] CAP = (CW+1)'(LINE_CAPACITY);

    logic [CW-1:0] r_chars, n_chars;
    logic r_ovf, n_ovf, r_nul, n_nul, r_inside, n_inside;
    logic [1:0] r_tc, n_tc;
    logic [scp_pkg::KW_COUNT-1:0] r_alive, n_alive, fin_alive;
    logic [scp_pkg::TOK_POS_W-1:0] r_pos, n_pos;
    logic [31:0] r_num, n_num;
    scp_pkg::t_num r_ns, n_ns;
    logic acc, is_sp, digit;
    logic [35:0] prod;
    logic [7:0] c;

    assign o_ready = !i_q_full;
    assign acc = i_valid && o_ready;
    assign c = i_rx_byte;
    assign is_sp = (c == scp_pkg::CH_SP) || (c == scp_pkg::CH_TAB);
    assign digit = (c >= scp_pkg::CH_ZERO) && (c <= scp_pkg::CH_NINE);
    assign prod = {r_num, 3'b000} + {3'b000, r_num, 1'b0} + {32'd0, c[3:0] - 4'd0};

    always_comb begin
        fin_alive = r_alive;
        for (int k = 0; k < scp_pkg::KW_COUNT; k++) begin
            if (r_pos != scp_pkg::kw_len(k)) fin_alive[k] = 1'b0;
        end
    end

    always_comb begin
        n_chars = r_chars; n_ovf = r_ovf; n_nul = r_nul; n_inside = r_inside;
        n_tc = r_tc; n_alive = r_alive; n_pos = r_pos; n_num = r_num; n_ns = r_ns;
        o_push = 1'b0;
        o_rec.ready_evt = 1'b0;
        o_rec.overflow = r_ovf;
        o_rec.tok_cnt = r_tc;
        o_rec.kw_alive = (r_inside && r_tc == 2'd1) ? fin_alive : r_alive;
        o_rec.num_valid = (r_ns == scp_pkg::NUM_VALID);
        o_rec.num_val = r_num;
        o_rec.mounted = i_link_mounted;
        if (acc) begin
            priority if (i_cmd == scp_pkg::CMD_OPEN) begin
                o_push = 1'b1;
                o_rec.ready_evt = 1'b1;
            end else if (i_cmd == scp_pkg::CMD_DETACH
                         || (i_cmd == scp_pkg::CMD_BYTE && c == scp_pkg::CH_LF)) begin
                if (i_cmd == scp_pkg::CMD_BYTE) o_push = r_ovf || (r_tc != 2'd0);
                n_chars = '0; n_ovf = 1'b0; n_nul = 1'b0; n_inside = 1'b0; n_tc = 2'd0;
                n_alive = '1; n_pos = '0; n_num = '0; n_ns = scp_pkg::NUM_EMPTY;
            end else if (i_cmd == scp_pkg::CMD_BYTE && c != scp_pkg::CH_CR) begin
                if ({1'b0, r_chars} + 1'b1 >= CAP) begin
                    n_ovf = 1'b1;
                end else begin
                    n_chars = r_chars + 1'b1;
                    if (!r_nul) begin
                        if (c == scp_pkg::CH_NUL) begin
                            n_nul = 1'b1;
                        end else if (is_sp) begin
                            if (r_inside && r_tc == 2'd1) n_alive = fin_alive;
                            n_inside = 1'b0;
                        end else begin
                            n_inside = 1'b1;
                            if (!r_inside && r_tc != 2'd3) n_tc = r_tc + 2'd1;
                            if (n_tc == 2'd1) begin
                                for (int k = 0; k < scp_pkg::KW_COUNT; k++) begin
                                    if (r_pos >= scp_pkg::kw_len(k)
                                        || c != scp_pkg::kw_char(k, r_pos[2:0]))
                                        n_alive[k] = 1'b0;
                                end
                                if (r_pos != scp_pkg::TOK_POS_MAX) n_pos = r_pos + 1'b1;
                            end else if (n_tc == 2'd2) begin
                                priority if (r_ns == scp_pkg::NUM_EMPTY
                                             && c == scp_pkg::CH_PLUS) begin
                                    n_ns = scp_pkg::NUM_PLUS;
                                end else if (digit && r_ns != scp_pkg::NUM_BAD) begin
                                    n_num = (r_ns == scp_pkg::NUM_VALID) ? prod[31:0]
                                            : {28'd0, c[3:0]};
                                    n_ns = (r_ns == scp_pkg::NUM_VALID && prod[35:32] != 4'd0)
                                           ? scp_pkg::NUM_BAD : scp_pkg::NUM_VALID;
                                end else begin
                                    n_ns = scp_pkg::NUM_BAD;
                                end
                            end
                        end
                    end
                end
            end else begin
                // CR and the unused command leave the line as it is
                n_chars = r_chars;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars <= '0; r_ovf <= 1'b0; r_nul <= 1'b0; r_inside <= 1'b0; r_tc <= 2'd0;
            r_alive <= '1; r_pos <= '0; r_num <= '0; r_ns <= scp_pkg::NUM_EMPTY;
        end else begin
            r_chars <= n_chars; r_ovf <= n_ovf; r_nul <= n_nul; r_inside <= n_inside;
            r_tc <= n_tc; r_alive <= n_alive; r_pos <= n_pos; r_num <= n_num; r_ns <= n_ns;
        end
    end
endmodule

[rtl/scp_queue.sv]
// Two-entry line record queue between front and back.
// Depends on scp_pkg.
module scp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  scp_pkg::t_line_rec   i_rec,
    input  logic                 i_pop,
    output scp_pkg::t_line_rec   o_rec,
    output scp_pkg::t_q_stat     o_stat
);
    scp_pkg::t_line_rec r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_rec = r_mem[r_rp];
    assign o_stat.full = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

[rtl/scp_back.sv]
// Back end: decides the reply for a line record, keeps the saved reply.
// Depends on scp_pkg.
module scp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  scp_pkg::t_line_rec   i_rec,
    input  scp_pkg::t_q_stat     i_stat,
    output logic                 o_pop,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [2:0]           o_kind,
    output logic [2:0]           o_code,
    output logic [31:0]          o_seq,
    output logic                 o_mounted,
    output logic [31:0]          o_prev,
    output logic                 o_replay
);
    logic [7:0] r_proto;
    logic r_has, r_smnt, r_ov;
    logic [31:0] r_sseq, r_sprev;
    scp_pkg::t_kind r_skind;
    logic save;
    scp_pkg::t_kind kind, skind;
    scp_pkg::t_err code;
    logic [31:0] seq, prev, s;
    logic mnt, rep;
    logic [2:0] r_kind, r_code;
    logic [31:0] r_seq, r_prev;
    logic r_mnt, r_rep;

    assign o_pop = !i_stat.empty && (!r_ov || i_out_ready);
    assign s = i_rec.num_val;

    always_comb begin
        kind = scp_pkg::KIND_ERROR; code = scp_pkg::ERR_BAD_SEQ; seq = '0; prev = '0;
        mnt = 1'b0; rep = 1'b0; save = 1'b0; skind = scp_pkg::KIND_PONG;
        priority if (i_rec.ready_evt) begin
            kind = scp_pkg::KIND_READY;
        end else if (i_rec.overflow) begin
            code = scp_pkg::ERR_TOO_LONG;
        end else if (i_rec.kw_alive[scp_pkg::KW_HELLO]) begin
            priority if (i_rec.tok_cnt != 2'd2) code = scp_pkg::ERR_BAD_HELLO;
            else if (!i_rec.num_valid || s != {24'd0, r_proto}) code = scp_pkg::ERR_BAD_PROTO;
            else kind = scp_pkg::KIND_READY;
        end else if (i_rec.tok_cnt < 2'd2 || !i_rec.num_valid) begin
            code = scp_pkg::ERR_BAD_SEQ;
        end else if (i_rec.tok_cnt == 2'd3) begin
            code = scp_pkg::ERR_FIELDS; seq = s;
        end else if (r_has && s == r_sseq) begin
            kind = r_skind; seq = r_sseq; mnt = r_smnt; prev = r_sprev; rep = 1'b1;
        end else if (r_has && s < r_sseq) begin
            code = scp_pkg::ERR_OLD_SEQ; seq = s;
        end else if (i_rec.kw_alive[scp_pkg::KW_PING]) begin
            kind = scp_pkg::KIND_PONG; seq = s; save = 1'b1;
        end else if (i_rec.kw_alive[scp_pkg::KW_STATUS]) begin
            kind = scp_pkg::KIND_STATE; seq = s; save = 1'b1;
            mnt = i_rec.mounted; prev = r_has ? r_sseq : 32'd0;
        end else if (i_rec.kw_alive[scp_pkg::KW_RESET] || i_rec.kw_alive[scp_pkg::KW_CANCEL]) begin
            kind = scp_pkg::KIND_ACK_RESET; seq = s; save = 1'b1;
        end else begin
            code = scp_pkg::ERR_BAD_CMD; seq = s;
        end
        if (kind != scp_pkg::KIND_ERROR) code = scp_pkg::ERR_BAD_SEQ;
        skind = kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proto <= 8'd1; r_has <= 1'b0; r_sseq <= '0; r_sprev <= '0;
            r_smnt <= 1'b0; r_skind <= scp_pkg::KIND_READY; r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) r_proto <= i_cfg_data;
            if (o_pop) begin
                r_ov <= 1'b1;
                if (save) begin
                    r_has <= 1'b1; r_sseq <= seq; r_sprev <= prev;
                    r_smnt <= mnt; r_skind <= skind;
                end
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= kind; r_code <= code; r_seq <= seq;
            r_prev <= prev; r_mnt <= mnt; r_rep <= rep;
        end
    end

    assign o_out_valid = r_ov;
    assign o_kind = r_kind;
    assign o_code = r_code;
    assign o_seq = r_seq;
    assign o_mounted = r_mnt;
    assign o_prev = r_prev;
    assign o_replay = r_rep;
endmodule

[rtl/sequenced_command_line_parser_core.sv]
// Top level of the sequenced command line parser: front, queue, back.
// Depends on scp_pkg, scp_ifs, scp_front, scp_queue, scp_back.
//
//  channel  dir  contents
//  i_in     in   cmd, rx_byte, link_mounted
//  o_out    out  reply_kind, error_code, reply_seq, reported_*, is_replay
//  i_cfg    in   protocol_version (8 bits)
//
// One input word per cycle while i_in.ready is high. With o_out free, a reply
// passes from its LF or open word into the queue, then through the back end's
// output register.
// i_in.ready drops only when the two-entry queue is full under output stall,
// and stays low that cycle even if a record leaves at its edge.
// Synchronous active-low reset; config port is always ready.
module sequenced_command_line_parser_core #(
    parameter int LINE_CAPACITY = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    scp_in_if.sink     i_in,
    scp_out_if.source  o_out,
    scp_cfg_if.sink    i_cfg
);
    logic push, pop;
    scp_pkg::t_line_rec rec_in, rec_out;
    scp_pkg::t_q_stat q_stat;

    assign i_cfg.ready = 1'b1;

    scp_front #(.LINE_CAPACITY(LINE_CAPACITY)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_in.valid), .i_cmd(i_in.cmd),
        .i_rx_byte(i_in.rx_byte), .i_link_mounted(i_in.link_mounted),
        .i_q_full(q_stat.full), .o_ready(i_in.ready), .o_push(push), .o_rec(rec_in)
    );

    scp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_rec(rec_in),
        .i_pop(pop), .o_rec(rec_out), .o_stat(q_stat)
    );

    scp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rec(rec_out), .i_stat(q_stat), .o_pop(pop),
        .i_cfg_we(i_cfg.valid), .i_cfg_data(i_cfg.data), .i_out_ready(o_out.ready),
        .o_out_valid(o_out.valid), .o_kind(o_out.reply_kind), .o_code(o_out.error_code),
        .o_seq(o_out.reply_seq), .o_mounted(o_out.reported_mounted),
        .o_prev(o_out.reported_prev_seq), .o_replay(o_out.is_replay)
    );

    a_q_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty)) else $error("queue full and empty");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty) else $error("pop from empty queue");
    a_replay_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_replay) |-> (o_out.error_code == scp_pkg::ERR_BAD_SEQ))
        else $error("replay carries error code");
endmodule

[tb/tb_sequenced_command_line_parser_core.sv]
// Testbench for the sequenced command line parser core: directed and random lines,
// replay, overflow and protocol settings checked against a local line predictor.
// Depends on scp_pkg, scp_ifs and the core RTL.
`timescale 1ns / 100ps

module tb_sequenced_command_line_parser_core;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  code;
        logic [31:0] seq;
        logic        mounted;
        logic [31:0] prev;
        logic        replay;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    scp_in_if  in_ch();
    scp_out_if out_ch();
    scp_cfg_if cfg_ch();

    sequenced_command_line_parser_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch), .i_cfg(cfg_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]  proto;
    int          chars;
    bit          ovf, in_tok, nul_in_line, have_saved;
    int          toks, tpos;
    logic [4:0]  alive;
    logic [35:0] nval;
    scp_pkg::t_num nstat;
    logic [31:0] sv_seq, sv_prev;
    logic [2:0]  sv_kind;
    logic        sv_mnt;

    t_reply replies_due[$];
    int     mismatches = 0;
    int     replies_seen = 0;
    int     words_sent = 0;
    bit     hold_rx = 1'b0;
    bit     rx_gaps = 1'b1;

    function automatic string kw_str(int k);
        case (k)
            scp_pkg::KW_PING:   return "PING";
            scp_pkg::KW_STATUS: return "STATUS";
            scp_pkg::KW_RESET:  return "RESET";
            scp_pkg::KW_CANCEL: return "CANCEL";
            default:            return "HELLO";
        endcase
    endfunction

    function automatic void line_clear();
        chars = 0; ovf = 0; toks = 0; in_tok = 0; alive = '1; tpos = 0;
        nval = '0; nstat = scp_pkg::NUM_EMPTY; nul_in_line = 0;
    endfunction

    function automatic void kw_close();
        for (int k = 0; k < scp_pkg::KW_COUNT; k++)
            if (tpos != kw_str(k).len()) alive[k] = 1'b0;
    endfunction

    function automatic void push_reply(logic [2:0] kd, logic [2:0] cd, logic [31:0] sq,
                                       logic m, logic [31:0] pv, logic rp);
        t_reply r;
        r = '{kd, cd, sq, m, pv, rp};
        replies_due.push_back(r);
    endfunction

    function automatic void line_end(logic mnt);
        logic [31:0] sq;
        if (ovf) begin
            push_reply(scp_pkg::KIND_ERROR, scp_pkg::ERR_TOO_LONG, 0, 0, 0, 0);
            return;
        end
        if (toks == 0) return;
        if (in_tok && toks == 1) kw_close();
        if (alive[scp_pkg::KW_HELLO]) begin
            if (toks != 2) push_reply(scp_pkg::KIND_ERROR, scp_pkg::ERR_BAD_HELLO, 0, 0, 0, 0);
            else if (nstat != scp_pkg::NUM_VALID || nval != {28'd0, proto})
                push_reply(scp_pkg::KIND_ERROR, scp_pkg::ERR_BAD_PROTO, 0, 0, 0, 0);
            else push_reply(scp_pkg::KIND_READY, 0, 0, 0, 0, 0);
            return;
        end
        if (toks < 2 || nstat != scp_pkg::NUM_VALID) begin
            push_reply(scp_pkg::KIND_ERROR, scp_pkg::ERR_BAD_SEQ, 0, 0, 0, 0);
            return;
        end
        sq = nval[31:0];
        if (toks >= 3) begin
            push_reply(scp_pkg::KIND_ERROR, scp_pkg::ERR_FIELDS, sq, 0, 0, 0);
            return;
        end
        if (have_saved && sq == sv_seq) begin
            push_reply(sv_kind, 0, sv_seq, sv_mnt, sv_prev, 1);
            return;
        end
        if (have_saved && sq < sv_seq) begin
            push_reply(scp_pkg::KIND_ERROR, scp_pkg::ERR_OLD_SEQ, sq, 0, 0, 0);
            return;
        end
        if (alive[scp_pkg::KW_PING]) begin
            sv_kind = scp_pkg::KIND_PONG; sv_mnt = 0; sv_prev = 0;
        end else if (alive[scp_pkg::KW_STATUS]) begin
            sv_prev = have_saved ? sv_seq : 32'd0;
            sv_kind = scp_pkg::KIND_STATE; sv_mnt = mnt;
        end else if (alive[scp_pkg::KW_RESET] || alive[scp_pkg::KW_CANCEL]) begin
            sv_kind = scp_pkg::KIND_ACK_RESET; sv_mnt = 0; sv_prev = 0;
        end else begin
            push_reply(scp_pkg::KIND_ERROR, scp_pkg::ERR_BAD_CMD, sq, 0, 0, 0);
            return;
        end
        sv_seq = sq;
        have_saved = 1;
        push_reply(sv_kind, 0, sv_seq, sv_mnt, sv_prev, 0);
    endfunction

    function automatic void parse_word(scp_pkg::t_cmd c, logic [7:0] b, logic mnt);
        if (c == scp_pkg::CMD_OPEN) begin
            push_reply(scp_pkg::KIND_READY, 0, 0, 0, 0, 0);
            return;
        end
        if (c == scp_pkg::CMD_DETACH) begin
            line_clear();
            return;
        end
        if (c != scp_pkg::CMD_BYTE || b == scp_pkg::CH_CR) return;
        if (b == scp_pkg::CH_LF) begin
            line_end(mnt);
            line_clear();
            return;
        end
        if (chars + 1 >= 128) begin
            ovf = 1;
            return;
        end
        chars++;
        if (nul_in_line) return;
        if (b == scp_pkg::CH_NUL) begin
            nul_in_line = 1;
            return;
        end
        if (b == scp_pkg::CH_SP || b == scp_pkg::CH_TAB) begin
            if (in_tok && toks == 1) kw_close();
            in_tok = 0;
            return;
        end
        if (!in_tok) begin
            in_tok = 1;
            if (toks < 3) toks++;
        end
        if (toks == 1) begin
            for (int k = 0; k < scp_pkg::KW_COUNT; k++)
                if (tpos >= kw_str(k).len() || b != kw_str(k)[tpos]) alive[k] = 1'b0;
            if (tpos < 127) tpos++;
        end else if (toks == 2) begin
            if (nstat == scp_pkg::NUM_EMPTY && b == scp_pkg::CH_PLUS) nstat = scp_pkg::NUM_PLUS;
            else if (b >= scp_pkg::CH_ZERO && b <= scp_pkg::CH_NINE
                     && nstat != scp_pkg::NUM_BAD) begin
                nval = (nstat == scp_pkg::NUM_VALID ? nval * 36'd10 : 36'd0)
                       + {28'd0, b - scp_pkg::CH_ZERO};
                nstat = (nval[35:32] != 4'd0) ? scp_pkg::NUM_BAD : scp_pkg::NUM_VALID;
            end else nstat = scp_pkg::NUM_BAD;
        end
    endfunction

    task automatic send_word(scp_pkg::t_cmd c, logic [7:0] b, logic mnt);
        int gap;
        gap = rx_gaps ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= c;
        in_ch.rx_byte <= b;
        in_ch.link_mounted <= mnt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        parse_word(c, b, mnt);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s, logic mnt = 1'b1);
        for (int i = 0; i < s.len(); i++) send_word(scp_pkg::CMD_BYTE, s[i], mnt);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (replies_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_proto(logic [7:0] v);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        proto = v;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // reply checker with random stalls
    always @(negedge i_clk) begin
        if (hold_rx) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(0, 6) == 0) ? 1'b0 : 1'b1;
    end

    always @(posedge i_clk) begin
        t_reply got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.reply_kind, out_ch.error_code, out_ch.reply_seq,
                    out_ch.reported_mounted, out_ch.reported_prev_seq, out_ch.is_replay};
            replies_seen++;
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected reply %p", got);
            end else begin
                want = replies_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("reply mismatch: exp %p got %p", want, got);
                end
            end
        end
    end

    task automatic test_directed();
        send_word(scp_pkg::CMD_OPEN, 8'hFF, 1'b0);
        send_text("HELLO 1\r\n");
        send_text("HELLO +01\n");
        send_text("HELLO\n");
        send_text("HELLO 2\n");
        send_text("PING 5\n");
        send_text("PING 5\n");
        send_text("\tSTATUS  7\n", 1'b1);
        send_text("RESET 9\n");
        send_text("CANCEL 4294967295\n");
        send_text("PING 4294967296\n");
        send_text("PING 9999999999\n");
        send_text("PING -3\n");
        send_text("PING 3\n");
        send_text("PING 1 2\n");
        send_text("PINGX 10\n");
        send_text("PING\n");
        send_text(" \t\r\n");
        send_text("PING 5");
        send_word(scp_pkg::CMD_DETACH, 8'h00, 1'b0);
        send_word(scp_pkg::CMD_UNUSED, 8'h41, 1'b1);
        send_text("\n");
        send_text("PI");
        send_word(scp_pkg::CMD_BYTE, scp_pkg::CH_NUL, 1'b0);
        send_text("NG 5\n");
        for (int i = 0; i < 130; i++) send_word(scp_pkg::CMD_BYTE, 8'h41, 1'b0);
        send_text("\n");
    endtask

    task automatic test_protocol();
        write_proto(8'd0);
        send_text("HELLO 0\n");
        send_text("HELLO 1\n");
        write_proto(8'd255);
        send_text("HELLO 255\n");
        send_text("HELLO +255\n");
        write_proto(8'd170);
        send_text("HELLO 170\n");
        write_proto(8'd85);
        send_text("HELLO 85\n");
    endtask

    task automatic test_random(int target);
        string s;
        int r;
        logic [31:0] base;
        base = sv_seq;
        while (words_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                base = base + $urandom_range(0, 3) - (($urandom_range(0, 7) == 0) ? 2 : 0);
                case ($urandom_range(0, 5))
                    0: s = "PING";
                    1: s = "STATUS";
                    2: s = "RESET";
                    3: s = "CANCEL";
                    4: s = "HELLO";
                    default: s = "PONG";
                endcase
                s = {s, ($urandom_range(0, 1) ? " " : "\t")};
                if ($urandom_range(0, 3) == 0) s = {s, "+"};
                s = {s, $sformatf("%0d", ($urandom_range(0, 9) == 0) ? $urandom() : base)};
                if ($urandom_range(0, 9) == 0) s = {s, " x"};
                if ($urandom_range(0, 9) == 0) s = {s, "\r"};
                send_text({s, "\n"}, 1'($urandom_range(0, 1)));
            end else if (r < 85) begin
                for (int i = $urandom_range(0, 12); i > 0; i--)
                    send_word(scp_pkg::CMD_BYTE, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                send_text("\n");
            end else if (r < 95) begin
                send_word(scp_pkg::t_cmd'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end else begin
                for (int i = $urandom_range(120, 140); i > 0; i--)
                    send_word(scp_pkg::CMD_BYTE, 8'h61, 1'b0);
                send_text("\n");
            end
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (300) @(negedge i_clk);
                hold_rx = 1'b0;
            end
            begin
                rx_gaps = 1'b0;
                for (int i = 0; i < 12; i++) send_word(scp_pkg::CMD_OPEN, 8'h00, 1'b0);
                in_ch.valid <= 1'b0;
                rx_gaps = 1'b1;
            end
        join
        wait_drained();
        send_text("PING 1\n");
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.cmd = scp_pkg::CMD_BYTE;
        in_ch.rx_byte = 8'h00;
        in_ch.link_mounted = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 8'h00;
        proto = 8'd1;
        have_saved = 0; sv_seq = 0; sv_kind = 0; sv_mnt = 0; sv_prev = 0;
        line_clear();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_protocol();
        write_proto(8'd1);
        test_backpressure();
        test_random(1750);
        wait_drained();
        repeat (20) @(negedge i_clk);
        $display("covered %0d input words and %0d replies over 5 protocol settings",
                 words_sent, replies_seen);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("sequenced_command_line_parser_core: match");
        end else begin
            $display("%0d mismatches, %0d replies outstanding", mismatches,
                     replies_due.size());
            $display("sequenced_command_line_parser_core: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("sequenced_command_line_parser_core: mismatch");
        $finish;
    end

endmodule

[sequenced_command_line_parser_core.f]
rtl/scp_pkg.sv
rtl/scp_ifs.sv
rtl/scp_front.sv
rtl/scp_queue.sv
rtl/scp_back.sv
rtl/sequenced_command_line_parser_core.sv
tb/tb_sequenced_command_line_parser_core.sv
